>>> rtl/oncg_pkg.sv
// Shared types, constants and helpers for the octree neighbour code generator.
package oncg_pkg;

   // Fixed field widths
   localparam int CODE_BITS      = 63;
   localparam int LEVEL_BITS     = 5;
   localparam int ROOT_BITS      = 21;
   localparam int DEPTH_BITS     = 5;
   localparam int CSR_INDEX_BITS = 2;
   localparam int NB_COUNT       = 26;

   // Signed width for box compares: covers root + 2^31 and corner - 2^31
   localparam int CMP_BITS = 35;

   localparam logic [DEPTH_BITS-1:0] DEPTH_RESET = 5'd21;

   // Result status codes
   typedef enum logic [1:0] {
      ST_NEIGHBOUR = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_LEVEL     = 2'd2,
      ST_OUTSIDE   = 2'd3
   } status_type;

   // Register indexes on the configuration port
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ROOT_X     = 2'd0,
      CSR_ROOT_Y     = 2'd1,
      CSR_ROOT_Z     = 2'd2,
      CSR_TREE_DEPTH = 2'd3
   } csr_type;

   // Per-axis offset selection
   typedef enum logic [1:0] {
      OFF_MINUS = 2'd0,
      OFF_ZERO  = 2'd1,
      OFF_PLUS  = 2'd2
   } off_type;

   // Classification of one item as handed from front to back
   typedef struct packed {
      status_type            status;
      logic [NB_COUNT-1:0]   hits;
      logic [LEVEL_BITS-1:0] level;
   } cls_type;

   // Position of offset triple (a, b, c) in emit order; the center is skipped
   function automatic int nb_index(input int a, input int b, input int c);
      int n;
      n = 9 * a + 3 * b + c;
      return (n > 13) ? n - 1 : n;
   endfunction

endpackage

>>> rtl/oncg_front.sv
// Front end: accepts a beat, decodes the corner and classifies every neighbour.
module oncg_front #(
   parameter int COORD_BITS = 21
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [oncg_pkg::CODE_BITS-1:0]    req_octant_code,
   input  logic [oncg_pkg::LEVEL_BITS-1:0]   req_octant_level,
   input  logic [oncg_pkg::ROOT_BITS-1:0]    root_x,
   input  logic [oncg_pkg::ROOT_BITS-1:0]    root_y,
   input  logic [oncg_pkg::ROOT_BITS-1:0]    root_z,
   input  logic [oncg_pkg::DEPTH_BITS-1:0]   tree_depth,
   input  logic                              q_full,
   output logic                              q_push,
   output oncg_pkg::cls_type                 q_cls,
   output logic [COORD_BITS-1:0]             q_x,
   output logic [COORD_BITS-1:0]             q_y,
   output logic [COORD_BITS-1:0]             q_z
);
   import oncg_pkg::*;

   logic                  s1_valid_ff, s1_valid_in;
   logic [CODE_BITS-1:0]  s1_code_ff, s1_code_in;
   logic [LEVEL_BITS-1:0] s1_level_ff, s1_level_in;

   logic                  accept;
   logic [COORD_BITS-1:0] cx, cy, cz;

   logic signed [CMP_BITS-1:0] size_w, ext_w;
   logic signed [CMP_BITS-1:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
   logic signed [CMP_BITS-1:0] cx_w, cy_w, cz_w;
   logic [2:0]                 in_x, in_y, in_z;
   logic [NB_COUNT-1:0]        hits;

   // Input register; holds while the queue is full
   assign req_stall = s1_valid_ff && q_full;
   assign accept    = req_valid && !req_stall;
   assign q_push    = s1_valid_ff && !q_full;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_code_in  = s1_code_ff;
      s1_level_in = s1_level_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_code_in  = req_octant_code;
         s1_level_in = req_octant_level;
      end else if (q_push) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_code_ff  <= s1_code_in;
      s1_level_ff <= s1_level_in;
   end

   // De-interleave and clear coordinate bits below the level
   always_comb begin
      cx = '0;
      cy = '0;
      cz = '0;
      for (int i = 0; i < COORD_BITS; i++) begin
         if (!(LEVEL_BITS'(i) < s1_level_ff)) begin
            cx[i] = s1_code_ff[3 * i + 2];
            cy[i] = s1_code_ff[3 * i + 1];
            cz[i] = s1_code_ff[3 * i];
         end
      end
   end

   // Box bounds and candidate coordinates per axis
   assign size_w = CMP_BITS'(1) << s1_level_ff;
   assign ext_w  = (CMP_BITS'(1) << tree_depth) - CMP_BITS'(1);
   assign lo_x   = CMP_BITS'(root_x);
   assign lo_y   = CMP_BITS'(root_y);
   assign lo_z   = CMP_BITS'(root_z);
   assign hi_x   = lo_x + ext_w;
   assign hi_y   = lo_y + ext_w;
   assign hi_z   = lo_z + ext_w;
   assign cx_w   = CMP_BITS'(cx);
   assign cy_w   = CMP_BITS'(cy);
   assign cz_w   = CMP_BITS'(cz);

   always_comb begin
      logic signed [CMP_BITS-1:0] vx, vy, vz;
      for (int k = 0; k < 3; k++) begin
         vx = (k == 0) ? cx_w - size_w : ((k == 2) ? cx_w + size_w : cx_w);
         vy = (k == 0) ? cy_w - size_w : ((k == 2) ? cy_w + size_w : cy_w);
         vz = (k == 0) ? cz_w - size_w : ((k == 2) ? cz_w + size_w : cz_w);
         in_x[k] = (vx >= lo_x) && (vx <= hi_x);
         in_y[k] = (vy >= lo_y) && (vy <= hi_y);
         in_z[k] = (vz >= lo_z) && (vz <= hi_z);
      end
   end

   // One hit bit per neighbour, in emit order
   for (genvar ga = 0; ga < 3; ga++) begin : g_a
      for (genvar gb = 0; gb < 3; gb++) begin : g_b
         for (genvar gc = 0; gc < 3; gc++) begin : g_c
            if (!(ga == 1 && gb == 1 && gc == 1)) begin : g_nb
               localparam int K = nb_index(ga, gb, gc);
               assign hits[K] = in_x[ga] && in_y[gb] && in_z[gc];
            end
         end
      end
   end

   // Classify
   always_comb begin
      q_cls.level  = s1_level_ff;
      q_cls.hits   = '0;
      q_cls.status = ST_NEIGHBOUR;
      if (s1_level_ff > tree_depth) begin
         q_cls.status = ST_LEVEL;
      end else if (!(in_x[1] && in_y[1] && in_z[1])) begin
         q_cls.status = ST_OUTSIDE;
      end else begin
         q_cls.hits = hits;
      end
   end

   assign q_x = cx;
   assign q_y = cy;
   assign q_z = cz;

endmodule

>>> rtl/oncg_queue.sv
// Small FIFO between the front and back ends.
module oncg_queue #(
   parameter int DATA_BITS = 96,
   parameter int DEPTH     = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [DATA_BITS-1:0] push_data,
   output logic                 full,
   input  logic                 pop,
   output logic [DATA_BITS-1:0] pop_data,
   output logic                 not_empty
);
   localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   logic [DATA_BITS-1:0]  mem [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign full      = (count_ff == COUNT_BITS'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = mem[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/oncg_back.sv
// Back end: walks the hit mask of one item and emits one result beat per cycle while rsp_stall is low.
module oncg_back #(
   parameter int COORD_BITS = 21
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_not_empty,
   output logic                              q_pop,
   input  oncg_pkg::cls_type                 q_cls,
   input  logic [COORD_BITS-1:0]             q_x,
   input  logic [COORD_BITS-1:0]             q_y,
   input  logic [COORD_BITS-1:0]             q_z,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [oncg_pkg::CODE_BITS-1:0]    rsp_neighbour_code,
   output logic [1:0]                        rsp_status,
   output logic                              rsp_last
);
   import oncg_pkg::*;

   // Current item
   logic                  cur_valid_ff, cur_valid_in;
   cls_type               cur_cls_ff, cur_cls_in;
   logic [COORD_BITS-1:0] cur_x_ff, cur_x_in;
   logic [COORD_BITS-1:0] cur_y_ff, cur_y_in;
   logic [COORD_BITS-1:0] cur_z_ff, cur_z_in;

   // Output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CODE_BITS-1:0]  rsp_code_ff, rsp_code_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  out_free, emit, done;
   logic [NB_COUNT-1:0]   first, rest;
   off_type               sel_x, sel_y, sel_z;
   logic [COORD_BITS-1:0] size_c, nx, ny, nz;
   logic [CODE_BITS-1:0]  nb_code;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit     = cur_valid_ff && out_free;

   // Lowest pending neighbour
   assign first = cur_cls_ff.hits & (~cur_cls_ff.hits + NB_COUNT'(1));
   assign rest  = cur_cls_ff.hits & ~first;

   always_comb begin
      sel_x = OFF_ZERO;
      sel_y = OFF_ZERO;
      sel_z = OFF_ZERO;
      for (int a = 0; a < 3; a++) begin
         for (int b = 0; b < 3; b++) begin
            for (int c = 0; c < 3; c++) begin
               if (!(a == 1 && b == 1 && c == 1)) begin
                  if (first[nb_index(a, b, c)]) begin
                     sel_x = off_type'(2'(a));
                     sel_y = off_type'(2'(b));
                     sel_z = off_type'(2'(c));
                  end
               end
            end
         end
      end
   end

   // Octant size, truncated to coordinate width
   always_comb begin
      size_c = '0;
      for (int i = 0; i < COORD_BITS; i++) begin
         if (cur_cls_ff.level == LEVEL_BITS'(i)) begin
            size_c[i] = 1'b1;
         end
      end
   end

   // Neighbour corner, low coordinate bits only
   function automatic logic [COORD_BITS-1:0] step(input logic [COORD_BITS-1:0] v,
                                                 input logic [COORD_BITS-1:0] d,
                                                 input off_type sel);
      case (sel)
         OFF_MINUS: return v - d;
         OFF_PLUS:  return v + d;
         default:   return v;
      endcase
   endfunction

   assign nx = step(cur_x_ff, size_c, sel_x);
   assign ny = step(cur_y_ff, size_c, sel_y);
   assign nz = step(cur_z_ff, size_c, sel_z);

   // Re-interleave
   always_comb begin
      nb_code = '0;
      for (int i = 0; i < COORD_BITS; i++) begin
         nb_code[3 * i + 2] = nx[i];
         nb_code[3 * i + 1] = ny[i];
         nb_code[3 * i]     = nz[i];
      end
   end

   // Result beat
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_code_in   = rsp_code_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      done          = 1'b0;
      if (emit) begin
         rsp_valid_in = 1'b1;
         if (cur_cls_ff.status != ST_NEIGHBOUR) begin
            rsp_code_in   = '0;
            rsp_status_in = cur_cls_ff.status;
            rsp_last_in   = 1'b1;
            done          = 1'b1;
         end else if (cur_cls_ff.hits == '0) begin
            rsp_code_in   = '0;
            rsp_status_in = ST_EMPTY;
            rsp_last_in   = 1'b1;
            done          = 1'b1;
         end else begin
            rsp_code_in   = nb_code;
            rsp_status_in = ST_NEIGHBOUR;
            rsp_last_in   = (rest == '0);
            done          = (rest == '0);
         end
      end
   end

   // Item register: load from the queue when no item is held or the current item is finished
   assign q_pop = q_not_empty && (!cur_valid_ff || done);

   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_cls_in   = cur_cls_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      cur_z_in     = cur_z_ff;
      if (q_pop) begin
         cur_valid_in = 1'b1;
         cur_cls_in   = q_cls;
         cur_x_in     = q_x;
         cur_y_in     = q_y;
         cur_z_in     = q_z;
      end else if (done) begin
         cur_valid_in = 1'b0;
      end else if (emit) begin
         cur_cls_in.hits = rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_cls_ff    <= cur_cls_in;
      cur_x_ff      <= cur_x_in;
      cur_y_ff      <= cur_y_in;
      cur_z_ff      <= cur_z_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_neighbour_code = rsp_code_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

>>> rtl/octree_neighbour_code_generator_top.sv
// Top level of the octree neighbour code generator: registers, front, queue, back.
//
// Each request beat carries a Morton code and a level. The block returns the
// Morton codes of the up to 26 neighbouring octant corners that fall inside the
// tree's box, in x-outer, z-inner order, with last set on the final beat; a
// single beat with a status code reports level above depth, an octant outside
// the tree, or no neighbours. Results leave at one beat per cycle while rsp_stall
// is low, so an item gives max(1, neighbour count) result beats, 26 at most; that
// one-code-per-cycle walk in the back end sets the throughput. The front end
// classifies an item held in its input register and a small queue lets it take
// new requests while the back end is still emitting. On its way to the result
// port an item passes input register, queue, item register and output register.
// Write the root and depth registers only while no request is in flight.
module octree_neighbour_code_generator_top #(
   parameter int COORD_BITS  = 21,
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [oncg_pkg::CODE_BITS-1:0]      req_octant_code,
   input  logic [oncg_pkg::LEVEL_BITS-1:0]     req_octant_level,
   // Result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [oncg_pkg::CODE_BITS-1:0]      rsp_neighbour_code,
   output logic [1:0]                          rsp_status,
   output logic                                rsp_last,
   // Register write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [oncg_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [oncg_pkg::ROOT_BITS-1:0]      csr_wdata
);
   import oncg_pkg::*;

   localparam int Q_BITS = $bits(cls_type) + 3 * COORD_BITS;

   logic [ROOT_BITS-1:0]  root_x_ff, root_y_ff, root_z_ff;
   logic [DEPTH_BITS-1:0] tree_depth_ff;

   logic                  q_full, q_push, q_pop, q_not_empty;
   cls_type               f_cls, b_cls;
   logic [COORD_BITS-1:0] f_x, f_y, f_z, b_x, b_y, b_z;
   logic [Q_BITS-1:0]     q_wdata, q_rdata;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         root_x_ff     <= '0;
         root_y_ff     <= '0;
         root_z_ff     <= '0;
         tree_depth_ff <= DEPTH_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_type'(csr_index))
            CSR_ROOT_X:     root_x_ff     <= csr_wdata;
            CSR_ROOT_Y:     root_y_ff     <= csr_wdata;
            CSR_ROOT_Z:     root_z_ff     <= csr_wdata;
            CSR_TREE_DEPTH: tree_depth_ff <= csr_wdata[DEPTH_BITS-1:0];
            default: ;
         endcase
      end
   end

   oncg_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_octant_code  (req_octant_code),
      .req_octant_level (req_octant_level),
      .root_x           (root_x_ff),
      .root_y           (root_y_ff),
      .root_z           (root_z_ff),
      .tree_depth       (tree_depth_ff),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_cls            (f_cls),
      .q_x              (f_x),
      .q_y              (f_y),
      .q_z              (f_z)
   );

   assign q_wdata = {f_cls, f_x, f_y, f_z};

   oncg_queue #(
      .DATA_BITS (Q_BITS),
      .DEPTH     (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .not_empty (q_not_empty)
   );

   assign {b_cls, b_x, b_y, b_z} = q_rdata;

   oncg_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_not_empty        (q_not_empty),
      .q_pop              (q_pop),
      .q_cls              (b_cls),
      .q_x                (b_x),
      .q_y                (b_y),
      .q_z                (b_z),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_neighbour_code (rsp_neighbour_code),
      .rsp_status         (rsp_status),
      .rsp_last           (rsp_last)
   );

endmodule
